[rtl/core/tmp_pkg.sv]
// Shared types and constants for the trapezoid motion profile core.
`timescale 1ns / 1ps

package tmp_pkg;

    localparam int FRAC_BITS = 8;

    // Field widths
    localparam int ACT_W   = 2;
    localparam int DIST_W  = 25;
    localparam int SPD_W   = 21;
    localparam int ACC_W   = 23;
    localparam int POS_W   = 32;
    localparam int PHASE_W = 2;
    localparam int DT_W    = 24;
    localparam int GOAL_W  = 24;
    localparam int ACCM_W  = 22;

    // Datapath widths
    localparam int MUL_A_W   = 25;
    localparam int MUL_B_W   = 24;
    localparam int PROD_W    = 49;
    localparam int SQ_W      = 41;
    localparam int REM_W     = 33;
    localparam int DV_W      = 22;
    localparam int SLEW_W    = 24;
    localparam int RND_SHIFT = 24;
    localparam int RND_W     = PROD_W - RND_SHIFT;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic CFG_IDX_TICK = 1'b0;

    localparam logic [DT_W-1:0]          DT_RESET    = 24'd33554;
    localparam logic [GOAL_W-1:0]        GOAL_MAX    = '1;
    localparam logic [SPD_W-2:0]         SPD_MAG_MAX = '1;
    localparam logic [ACCM_W-1:0]        ACC_MAG_MAX = '1;
    localparam logic [GOAL_W-1:0]        ONE_MAG     = GOAL_W'(2 ** FRAC_BITS);
    localparam logic [ACCM_W-1:0]        ACC_MIN     = ACCM_W'(2 ** FRAC_BITS);
    localparam logic signed [SPD_W-1:0]  CREEP       = SPD_W'(5 * (2 ** FRAC_BITS));
    localparam logic signed [REM_W-1:0]  FIN_THRESH  = REM_W'(2 ** (FRAC_BITS - 3));
    localparam logic [PROD_W-1:0]        RND_HALF    = PROD_W'(2 ** (RND_SHIFT - 1));
    localparam logic signed [POS_W-1:0]  POS_MAX     = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W-1:0]  POS_MIN     = {1'b1, {(POS_W-1){1'b0}}};

    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE  = 2'd0,
        PH_ACCEL = 2'd1,
        PH_BRAKE = 2'd2,
        PH_DONE  = 2'd3
    } phase_t;

    typedef enum logic [ACT_W-1:0] {
        ACT_TICK  = 2'd0,
        ACT_START = 2'd1,
        ACT_RESET = 2'd2
    } act_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_VSQ,
        S_ESQ,
        S_BRK,
        S_UPD,
        S_SLEW,
        S_PMUL,
        S_POS,
        S_OUT
    } state_t;

    typedef enum logic [2:0] {
        MS_ACCEL_DT,
        MS_SPEED_SQ,
        MS_END_SQ,
        MS_BRAKE,
        MS_SPEED_DT
    } mul_sel_t;

    typedef struct packed {
        logic     ld_in;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     ld_rem;
        logic     do_start;
        logic     do_clear;
        logic     ld_dv;
        logic     ld_vsq;
        logic     ld_diff;
        logic     brake_upd;
        logic     slew;
        logic     pos_upd;
        logic     ld_out;
    } dp_cmd_t;

    typedef struct packed {
        logic [ACT_W-1:0] act;
        phase_t           phase;
    } dp_stat_t;

endpackage

[rtl/core/tmp_move_if.sv]
// Input channel: one move command word per handshake.
`timescale 1ns / 1ps

interface tmp_move_if;
    logic                               valid;
    logic                               ready;
    logic [tmp_pkg::ACT_W-1:0]          action;
    logic signed [tmp_pkg::DIST_W-1:0]  distance;
    logic signed [tmp_pkg::SPD_W-1:0]   cruise_speed;
    logic signed [tmp_pkg::SPD_W-1:0]   exit_speed;
    logic signed [tmp_pkg::ACC_W-1:0]   acceleration;

    modport source (
        output valid, action, distance, cruise_speed, exit_speed, acceleration,
        input  ready
    );

    modport sink (
        input  valid, action, distance, cruise_speed, exit_speed, acceleration,
        output ready
    );
endinterface

[rtl/core/tmp_status_if.sv]
// Output channel: one profile status word per handshake.
`timescale 1ns / 1ps

interface tmp_status_if;
    logic                               valid;
    logic                               ready;
    logic signed [tmp_pkg::SPD_W-1:0]   speed;
    logic signed [tmp_pkg::POS_W-1:0]   position;
    logic [tmp_pkg::PHASE_W-1:0]        phase;
    logic                               finished;

    modport source (
        output valid, speed, position, phase, finished,
        input  ready
    );

    modport sink (
        input  valid, speed, position, phase, finished,
        output ready
    );
endinterface

[rtl/core/tmp_ctrl.sv]
// Sequencer for the motion profile: steps the datapath through one word.
`timescale 1ns / 1ps

module tmp_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  tmp_pkg::dp_stat_t  stat,
    output tmp_pkg::dp_cmd_t   cmd
);

    tmp_pkg::state_t state_reg, state_next;
    logic            out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tmp_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tmp_pkg::S_IDLE:
            begin
                if (in_valid)
                    state_next = tmp_pkg::S_EXEC;
            end
            tmp_pkg::S_EXEC:
            begin
                if (stat.act == tmp_pkg::ACT_TICK && stat.phase != tmp_pkg::PH_IDLE)
                    state_next = tmp_pkg::S_VSQ;
                else
                    state_next = tmp_pkg::S_OUT;
            end
            tmp_pkg::S_VSQ:  state_next = tmp_pkg::S_ESQ;
            tmp_pkg::S_ESQ:  state_next = tmp_pkg::S_BRK;
            tmp_pkg::S_BRK:  state_next = tmp_pkg::S_UPD;
            tmp_pkg::S_UPD:  state_next = tmp_pkg::S_SLEW;
            tmp_pkg::S_SLEW: state_next = tmp_pkg::S_PMUL;
            tmp_pkg::S_PMUL: state_next = tmp_pkg::S_POS;
            tmp_pkg::S_POS:  state_next = tmp_pkg::S_OUT;
            tmp_pkg::S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = tmp_pkg::S_IDLE;
            end
            default: state_next = tmp_pkg::S_IDLE;
        endcase
    end

    // Commands
    always_comb
    begin
        cmd = '0;
        cmd.mul_sel = tmp_pkg::MS_ACCEL_DT;
        unique case (state_reg)
            tmp_pkg::S_IDLE:
            begin
                cmd.ld_in = in_valid;
            end
            tmp_pkg::S_EXEC:
            begin
                // a*dt and remaining distance are formed for every word; only ticks use them
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = tmp_pkg::MS_ACCEL_DT;
                cmd.ld_rem   = 1'b1;
                cmd.do_start = (stat.act == tmp_pkg::ACT_START);
                cmd.do_clear = (stat.act == tmp_pkg::ACT_RESET);
            end
            tmp_pkg::S_VSQ:
            begin
                cmd.ld_dv   = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = tmp_pkg::MS_SPEED_SQ;
            end
            tmp_pkg::S_ESQ:
            begin
                cmd.ld_vsq  = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = tmp_pkg::MS_END_SQ;
            end
            tmp_pkg::S_BRK:
            begin
                cmd.ld_diff = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = tmp_pkg::MS_BRAKE;
            end
            tmp_pkg::S_UPD:
            begin
                cmd.brake_upd = 1'b1;
            end
            tmp_pkg::S_SLEW:
            begin
                cmd.slew = 1'b1;
            end
            tmp_pkg::S_PMUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = tmp_pkg::MS_SPEED_DT;
            end
            tmp_pkg::S_POS:
            begin
                cmd.pos_upd = 1'b1;
            end
            tmp_pkg::S_OUT:
            begin
                cmd.ld_out = !out_valid_reg || out_ready;
            end
            default:
            begin
                cmd.ld_in = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.ld_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign in_ready  = (state_reg == tmp_pkg::S_IDLE);
    assign out_valid = out_valid_reg;

    // A finished word waits in S_OUT while the previous result is still held
    a_out_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tmp_pkg::S_OUT && out_valid_reg && !out_ready)
        |=> (state_reg == tmp_pkg::S_OUT && out_valid_reg))
        else $error("sequencer left S_OUT while the output word was stalled");

endmodule

[rtl/core/tmp_dp.sv]
// Datapath for the motion profile: profile state, shared multiplier, output word.
`timescale 1ns / 1ps

module tmp_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  tmp_pkg::dp_cmd_t                    cmd,
    output tmp_pkg::dp_stat_t                   stat,
    input  logic [tmp_pkg::DT_W-1:0]            tick_interval,
    input  logic [tmp_pkg::ACT_W-1:0]           action,
    input  logic signed [tmp_pkg::DIST_W-1:0]   distance,
    input  logic signed [tmp_pkg::SPD_W-1:0]    cruise_speed,
    input  logic signed [tmp_pkg::SPD_W-1:0]    exit_speed,
    input  logic signed [tmp_pkg::ACC_W-1:0]    acceleration,
    output logic signed [tmp_pkg::SPD_W-1:0]    speed,
    output logic signed [tmp_pkg::POS_W-1:0]    position,
    output logic [tmp_pkg::PHASE_W-1:0]         phase,
    output logic                                finished
);

    function automatic logic [tmp_pkg::RND_W-1:0] round_dt(
        input logic [tmp_pkg::PROD_W-1:0] p
    );
        logic [tmp_pkg::PROD_W-1:0] s;
        s = p + tmp_pkg::RND_HALF;
        return s[tmp_pkg::PROD_W-1:tmp_pkg::RND_SHIFT];
    endfunction

    // Captured input word
    logic [tmp_pkg::ACT_W-1:0]          act_reg;
    logic signed [tmp_pkg::DIST_W-1:0]  dist_reg;
    logic signed [tmp_pkg::SPD_W-1:0]   top_reg;
    logic signed [tmp_pkg::SPD_W-1:0]   fin_reg;
    logic signed [tmp_pkg::ACC_W-1:0]   acc_reg;

    // Profile state
    tmp_pkg::phase_t                    phase_reg, phase_next;
    logic signed [tmp_pkg::POS_W-1:0]   position_reg, position_next;
    logic signed [tmp_pkg::SPD_W-1:0]   speed_reg, speed_next;
    logic signed [tmp_pkg::SPD_W-1:0]   target_reg, target_next;
    logic signed [tmp_pkg::SPD_W-1:0]   end_reg, end_next;
    logic [tmp_pkg::GOAL_W-1:0]         goal_reg, goal_next;
    logic [tmp_pkg::ACCM_W-1:0]         accel_reg, accel_next;
    logic                               dir_neg_reg, dir_neg_next;

    // Tick scratch
    logic signed [tmp_pkg::REM_W-1:0]   rem_reg;
    logic [tmp_pkg::PROD_W-1:0]         prod_reg;
    logic [tmp_pkg::DV_W-1:0]           dv_reg;
    logic [tmp_pkg::SQ_W-1:0]           vsq_reg;

    // Output word
    logic signed [tmp_pkg::SPD_W-1:0]   speed_o_reg;
    logic signed [tmp_pkg::POS_W-1:0]   position_o_reg;
    tmp_pkg::phase_t                    phase_o_reg;

    // Start decode
    logic                               dist_neg;
    logic [tmp_pkg::DIST_W-1:0]         dist_abs;
    logic [tmp_pkg::GOAL_W-1:0]         dist_mag;
    logic                               short_move;
    logic signed [tmp_pkg::SPD_W-1:0]   fin_cap;
    logic [tmp_pkg::SPD_W-1:0]          top_abs, fin_abs;
    logic [tmp_pkg::SPD_W-2:0]          top_mag, fin_mag;
    logic signed [tmp_pkg::SPD_W-1:0]   top_pos, fin_pos;
    logic [tmp_pkg::ACC_W-1:0]          acc_abs;
    logic [tmp_pkg::ACCM_W-1:0]         acc_mag;

    // Tick logic
    logic [tmp_pkg::POS_W-1:0]          pos_abs;
    logic signed [tmp_pkg::REM_W-1:0]   rem_calc;
    logic [tmp_pkg::SPD_W-1:0]          spd_abs, end_abs;
    logic [tmp_pkg::ACCM_W-1:0]         a_eff;
    logic [tmp_pkg::MUL_A_W-1:0]        rem_p1, mul_a;
    logic [tmp_pkg::MUL_B_W-1:0]        two_a, mul_b;
    logic [tmp_pkg::PROD_W-1:0]         mul_p;
    logic [tmp_pkg::RND_W-1:0]          rnd_q;
    logic [tmp_pkg::SQ_W-1:0]           diff;
    logic                               brake_hit;
    logic signed [tmp_pkg::SPD_W-1:0]   brake_tgt;
    logic signed [tmp_pkg::SLEW_W-1:0]  sp_ext, dv_ext, tg_ext, slew_up, slew_dn;
    logic signed [tmp_pkg::SPD_W-1:0]   slew_v;
    logic [tmp_pkg::SPD_W-1:0]          pd;
    logic signed [tmp_pkg::REM_W-1:0]   delta, pos_sum;
    logic signed [tmp_pkg::POS_W-1:0]   pos_new;
    logic                               fin_hit;

    always_ff @(posedge clk)
    begin
        if (cmd.ld_in)
        begin
            act_reg  <= action;
            dist_reg <= distance;
            top_reg  <= cruise_speed;
            fin_reg  <= exit_speed;
            acc_reg  <= acceleration;
        end
    end

    // ---- start decode ----
    always_comb
    begin
        dist_neg   = dist_reg[tmp_pkg::DIST_W-1];
        dist_abs   = dist_neg ? tmp_pkg::DIST_W'(-dist_reg) : tmp_pkg::DIST_W'(dist_reg);
        dist_mag   = (dist_abs > tmp_pkg::DIST_W'(tmp_pkg::GOAL_MAX))
                     ? tmp_pkg::GOAL_MAX : dist_abs[tmp_pkg::GOAL_W-1:0];
        short_move = (dist_mag < tmp_pkg::ONE_MAG);

        // final speed is capped at top speed before magnitudes are taken
        fin_cap = (fin_reg > top_reg) ? top_reg : fin_reg;

        top_abs = top_reg[tmp_pkg::SPD_W-1] ? tmp_pkg::SPD_W'(-top_reg)
                                             : tmp_pkg::SPD_W'(top_reg);
        fin_abs = fin_cap[tmp_pkg::SPD_W-1] ? tmp_pkg::SPD_W'(-fin_cap)
                                             : tmp_pkg::SPD_W'(fin_cap);
        top_mag = top_abs[tmp_pkg::SPD_W-1] ? tmp_pkg::SPD_MAG_MAX
                                             : top_abs[tmp_pkg::SPD_W-2:0];
        fin_mag = fin_abs[tmp_pkg::SPD_W-1] ? tmp_pkg::SPD_MAG_MAX
                                             : fin_abs[tmp_pkg::SPD_W-2:0];
        top_pos = {1'b0, top_mag};
        fin_pos = {1'b0, fin_mag};

        acc_abs = acc_reg[tmp_pkg::ACC_W-1] ? tmp_pkg::ACC_W'(-acc_reg)
                                             : tmp_pkg::ACC_W'(acc_reg);
        acc_mag = acc_abs[tmp_pkg::ACC_W-1] ? tmp_pkg::ACC_MAG_MAX
                                             : acc_abs[tmp_pkg::ACCM_W-1:0];
    end

    // ---- tick arithmetic ----
    always_comb
    begin
        pos_abs  = position_reg[tmp_pkg::POS_W-1] ? tmp_pkg::POS_W'(-position_reg)
                                                   : tmp_pkg::POS_W'(position_reg);
        rem_calc = $signed(tmp_pkg::REM_W'(goal_reg)) - $signed(tmp_pkg::REM_W'(pos_abs));

        spd_abs = speed_reg[tmp_pkg::SPD_W-1] ? tmp_pkg::SPD_W'(-speed_reg)
                                               : tmp_pkg::SPD_W'(speed_reg);
        end_abs = end_reg[tmp_pkg::SPD_W-1] ? tmp_pkg::SPD_W'(-end_reg)
                                             : tmp_pkg::SPD_W'(end_reg);

        a_eff  = (accel_reg < tmp_pkg::ACC_MIN) ? tmp_pkg::ACC_MIN : accel_reg;
        // only meaningful when remaining distance is not negative
        rem_p1 = tmp_pkg::MUL_A_W'(rem_reg[tmp_pkg::GOAL_W-1:0]) + tmp_pkg::MUL_A_W'(1);
        two_a  = tmp_pkg::MUL_B_W'({a_eff, 1'b0});

        unique case (cmd.mul_sel)
            tmp_pkg::MS_ACCEL_DT:
            begin
                mul_a = tmp_pkg::MUL_A_W'(accel_reg);
                mul_b = tick_interval;
            end
            tmp_pkg::MS_SPEED_SQ:
            begin
                mul_a = tmp_pkg::MUL_A_W'(spd_abs);
                mul_b = tmp_pkg::MUL_B_W'(spd_abs);
            end
            tmp_pkg::MS_END_SQ:
            begin
                mul_a = tmp_pkg::MUL_A_W'(end_abs);
                mul_b = tmp_pkg::MUL_B_W'(end_abs);
            end
            tmp_pkg::MS_BRAKE:
            begin
                mul_a = rem_p1;
                mul_b = two_a;
            end
            tmp_pkg::MS_SPEED_DT:
            begin
                mul_a = tmp_pkg::MUL_A_W'(spd_abs);
                mul_b = tick_interval;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = tmp_pkg::PROD_W'(mul_a) * tmp_pkg::PROD_W'(mul_b);

        rnd_q = round_dt(prod_reg);

        diff = (vsq_reg >= prod_reg[tmp_pkg::SQ_W-1:0])
               ? vsq_reg - prod_reg[tmp_pkg::SQ_W-1:0]
               : prod_reg[tmp_pkg::SQ_W-1:0] - vsq_reg;

        // remaining < floor(d / 2a)  <=>  remaining < 0  or  (remaining + 1) * 2a <= d
        brake_hit = (phase_reg == tmp_pkg::PH_ACCEL)
                    && (rem_reg[tmp_pkg::REM_W-1]
                        || (prod_reg <= tmp_pkg::PROD_W'(vsq_reg)));
        if (end_reg == '0)
            brake_tgt = dir_neg_reg ? -tmp_pkg::CREEP : tmp_pkg::CREEP;
        else
            brake_tgt = end_reg;

        sp_ext  = tmp_pkg::SLEW_W'(speed_reg);
        tg_ext  = tmp_pkg::SLEW_W'(target_reg);
        dv_ext  = $signed(tmp_pkg::SLEW_W'(dv_reg));
        slew_up = sp_ext + dv_ext;
        slew_dn = sp_ext - dv_ext;
        if (speed_reg < target_reg)
            slew_v = (slew_up > tg_ext) ? target_reg : tmp_pkg::SPD_W'(slew_up);
        else if (speed_reg > target_reg)
            slew_v = (slew_dn < tg_ext) ? target_reg : tmp_pkg::SPD_W'(slew_dn);
        else
            slew_v = speed_reg;

        pd      = rnd_q[tmp_pkg::SPD_W-1:0];
        delta   = speed_reg[tmp_pkg::SPD_W-1] ? -$signed(tmp_pkg::REM_W'(pd))
                                               : $signed(tmp_pkg::REM_W'(pd));
        pos_sum = tmp_pkg::REM_W'(position_reg) + delta;
        if (pos_sum[tmp_pkg::REM_W-1] == pos_sum[tmp_pkg::POS_W-1])
            pos_new = pos_sum[tmp_pkg::POS_W-1:0];
        else if (pos_sum[tmp_pkg::REM_W-1])
            pos_new = tmp_pkg::POS_MIN;
        else
            pos_new = tmp_pkg::POS_MAX;

        fin_hit = (phase_reg != tmp_pkg::PH_DONE) && (rem_reg < tmp_pkg::FIN_THRESH);
    end

    // ---- state update ----
    always_comb
    begin
        phase_next    = phase_reg;
        position_next = position_reg;
        speed_next    = speed_reg;
        target_next   = target_reg;
        end_next      = end_reg;
        goal_next     = goal_reg;
        accel_next    = accel_reg;
        dir_neg_next  = dir_neg_reg;

        if (cmd.do_start)
        begin
            dir_neg_next = dist_neg;
            // short move only flags finished and records direction; the rest of the state is kept
            if (short_move)
                phase_next = tmp_pkg::PH_DONE;
            else
            begin
                position_next = '0;
                goal_next     = dist_mag;
                target_next   = dist_neg ? -top_pos : top_pos;
                end_next      = dist_neg ? -fin_pos : fin_pos;
                accel_next    = acc_mag;
                phase_next    = tmp_pkg::PH_ACCEL;
            end
        end

        if (cmd.do_clear)
        begin
            position_next = '0;
            speed_next    = '0;
            target_next   = '0;
            phase_next    = tmp_pkg::PH_IDLE;
        end

        if (cmd.brake_upd && brake_hit)
        begin
            phase_next  = tmp_pkg::PH_BRAKE;
            target_next = brake_tgt;
        end

        if (cmd.slew)
            speed_next = slew_v;

        if (cmd.pos_upd)
        begin
            position_next = pos_new;
            if (fin_hit)
            begin
                phase_next  = tmp_pkg::PH_DONE;
                target_next = end_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= tmp_pkg::PH_IDLE;
            position_reg <= '0;
            speed_reg    <= '0;
            target_reg   <= '0;
            end_reg      <= '0;
            goal_reg     <= '0;
            accel_reg    <= '0;
            dir_neg_reg  <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            position_reg <= position_next;
            speed_reg    <= speed_next;
            target_reg   <= target_next;
            end_reg      <= end_next;
            goal_reg     <= goal_next;
            accel_reg    <= accel_next;
            dir_neg_reg  <= dir_neg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ld_rem)
            rem_reg <= rem_calc;
        if (cmd.mul_en)
            prod_reg <= mul_p;
        if (cmd.ld_dv)
            dv_reg <= rnd_q[tmp_pkg::DV_W-1:0];
        if (cmd.ld_vsq)
            vsq_reg <= prod_reg[tmp_pkg::SQ_W-1:0];
        else if (cmd.ld_diff)
            vsq_reg <= diff;
        if (cmd.ld_out)
        begin
            speed_o_reg    <= speed_reg;
            position_o_reg <= position_reg;
            phase_o_reg    <= phase_reg;
        end
    end

    assign stat.act   = act_reg;
    assign stat.phase = phase_reg;

    assign speed    = speed_o_reg;
    assign position = position_o_reg;
    assign phase    = phase_o_reg;
    assign finished = (phase_o_reg == tmp_pkg::PH_DONE);

    a_done_no_brake: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == tmp_pkg::PH_DONE) |=> (phase_reg != tmp_pkg::PH_BRAKE))
        else $error("finished move switched to braking");

    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == tmp_pkg::PH_IDLE && !cmd.do_start) |=> (phase_reg == tmp_pkg::PH_IDLE))
        else $error("profile left idle without a start");

    a_slew_no_overshoot: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.slew && speed_reg < target_reg) |=> (speed_reg <= target_reg))
        else $error("speed overshot its target while ramping up");

endmodule

[rtl/core/trapezoid_motion_profile_core.sv]
// Top level of the trapezoid motion profile core.
`timescale 1ns / 1ps

// Trapezoidal move generator.
// move channel (valid/ready): one command word per handshake. action tick
// advances the profile by one loop period, start loads a new move
// (distance, top/final speed, acceleration), reset clears position, speed,
// target and phase. status channel (valid/ready): one word per command,
// carrying speed, position, phase and the finished flag after the update.
// tick_interval (loop period, Q0.24 seconds) sits at APB address 0; the
// user must write it only while no command is in flight, since the block
// itself does not enforce it. A tick on a running move forms a*dt and the
// remaining distance, then v^2, vf^2 and the braking product, updates the
// phase, slews the speed, forms v*dt and updates the position before the
// status word is loaded, using the one shared 25x24 multiplier five times
// per tick. Start, reset, idle ticks and unused actions skip these steps.
// Reset (rst_n low) puts the profile in idle with zero state and the
// loop period at its default. A command is accepted while the previous
// status word still waits; if the receiver stalls, the new word waits in
// the sequencer until the status register frees, and no further command
// is taken meanwhile.
module trapezoid_motion_profile_core (
    input  logic                                clk,
    input  logic                                rst_n,
    tmp_move_if.sink                            move,
    tmp_status_if.source                        status,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tmp_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [tmp_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [tmp_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                pready
);

    logic [tmp_pkg::DT_W-1:0] tick_reg;
    logic                     cfg_idx;
    logic                     cfg_wr;
    tmp_pkg::dp_cmd_t         cmd;
    tmp_pkg::dp_stat_t        stat;

    assign cfg_idx = paddr[tmp_pkg::CFG_ADDR_W-1];
    assign cfg_wr  = psel && penable && pwrite && (cfg_idx == tmp_pkg::CFG_IDX_TICK);
    assign pready  = 1'b1;
    assign prdata  = (cfg_idx == tmp_pkg::CFG_IDX_TICK)
                     ? tmp_pkg::CFG_DATA_W'(tick_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tick_reg <= tmp_pkg::DT_RESET;
        else if (cfg_wr)
            tick_reg <= pwdata[tmp_pkg::DT_W-1:0];
    end

    tmp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (move.valid),
        .in_ready  (move.ready),
        .out_valid (status.valid),
        .out_ready (status.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    tmp_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .tick_interval (tick_reg),
        .action        (move.action),
        .distance      (move.distance),
        .cruise_speed  (move.cruise_speed),
        .exit_speed    (move.exit_speed),
        .acceleration  (move.acceleration),
        .speed         (status.speed),
        .position      (status.position),
        .phase         (status.phase),
        .finished      (status.finished)
    );

endmodule
